// File: design/fba_pkg.sv
`timescale 1ns / 1ps

package fba_pkg;

  localparam int unsigned NUM_FRAMES = 4096;
  localparam int unsigned WORD_BITS  = 32;
  localparam int unsigned WB_LOG     = $clog2(WORD_BITS);
  localparam int unsigned MAP_WORDS  = NUM_FRAMES / WORD_BITS;
  localparam int unsigned AW         = $clog2(MAP_WORDS);
  localparam int unsigned FW         = $clog2(NUM_FRAMES) + 1;
  localparam int unsigned IW         = FW - 1;
  localparam int unsigned PW         = WB_LOG + 1;

  typedef logic [WORD_BITS-1:0] word_t;

  localparam logic [2:0] FN_INIT    = 3'd0;
  localparam logic [2:0] FN_ALLOC   = 3'd1;
  localparam logic [2:0] FN_FREE    = 3'd2;
  localparam logic [2:0] FN_ALLOC_R = 3'd3;
  localparam logic [2:0] FN_FREE_R  = 3'd4;
  localparam logic [2:0] FN_RESERVE = 3'd5;
  localparam logic [2:0] FN_QUERY   = 3'd6;

  typedef struct packed {
    logic          hit;
    logic [FW-1:0] start;
    logic [FW-1:0] run_nx;
    logic [FW-1:0] start_nx;
  } fit_res_t;

  typedef struct packed {
    word_t         wdata;
    logic [PW-1:0] n;
  } rng_res_t;

  typedef struct packed {
    logic              found;
    logic [WB_LOG-1:0] bitpos;
  } low_res_t;

  // bit b set when frame base+b lies in [lo, hi)
  function automatic word_t range_mask(logic [FW-1:0] base, logic [FW:0] lo, logic [FW:0] hi);
    word_t     m;
    logic [FW:0] f;
    for (int b = 0; b < WORD_BITS; b++) begin
      f    = {1'b0, base} + (FW+1)'(b);
      m[b] = (f >= lo) && (f < hi);
    end
    return m;
  endfunction

  // index of lowest set bit, WORD_BITS when none
  function automatic logic [PW-1:0] lsb_index(word_t x);
    logic [PW-1:0] r;
    r = PW'(WORD_BITS);
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (x[b]) r = PW'(b);
    end
    return r;
  endfunction

  function automatic word_t bit_rev(word_t x);
    word_t r;
    for (int b = 0; b < WORD_BITS; b++) r[b] = x[WORD_BITS-1-b];
    return r;
  endfunction

  function automatic logic [PW-1:0] popcount(word_t x);
    logic [PW-1:0] s;
    s = '0;
    for (int b = 0; b < WORD_BITS; b++) s = s + PW'(x[b]);
    return s;
  endfunction

  // bit p set when clr[p +: c] are all ones inside the word
  function automatic word_t window(word_t clr, logic [WB_LOG-1:0] c);
    logic [WORD_BITS:0] acc;
    word_t              p;
    acc = '1;
    p   = clr;
    for (int k = 0; k < WB_LOG; k++) begin
      if (c[k]) acc = {1'b0, p} & (acc >> (1 << k));
      p = p & (p >> (1 << k));
    end
    return acc[WORD_BITS-1:0];
  endfunction

endpackage

// File: design/fba_map.sv
`timescale 1ns / 1ps

module fba_map (
  input  logic                   clk_i,
  input  logic                   rd_en_i,
  input  logic [fba_pkg::AW-1:0] rd_addr_i,
  output fba_pkg::word_t         rd_data_o,
  input  logic                   wr_en_i,
  input  logic [fba_pkg::AW-1:0] wr_addr_i,
  input  fba_pkg::word_t         wr_data_i
);

  fba_pkg::word_t mem [fba_pkg::MAP_WORDS];
  fba_pkg::word_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) mem[wr_addr_i] <= wr_data_i;
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) rd_data_q <= mem[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

// File: design/fba_word_eval.sv
`timescale 1ns / 1ps

module fba_word_eval (
  input  fba_pkg::word_t         word_i,
  input  logic [fba_pkg::AW-1:0] dw_i,
  input  logic [fba_pkg::FW-1:0] lim_i,
  input  logic [fba_pkg::FW-1:0] cnt_i,
  input  logic [fba_pkg::FW:0]   lo_i,
  input  logic [fba_pkg::FW:0]   hi_i,
  input  logic                   set_i,
  input  logic [fba_pkg::FW-1:0] run_i,
  input  logic [fba_pkg::FW-1:0] start_i,
  output fba_pkg::fit_res_t      fit_o,
  output fba_pkg::rng_res_t      rng_o,
  output fba_pkg::low_res_t      low_o
);

  logic [fba_pkg::FW-1:0] base;
  fba_pkg::word_t         clr;
  fba_pkg::word_t         win;
  fba_pkg::word_t         mask;
  logic [fba_pkg::PW-1:0] tz;
  logic [fba_pkg::PW-1:0] lz;
  logic [fba_pkg::PW-1:0] p;
  logic [fba_pkg::PW-1:0] zpos;
  logic                   carry;

  assign base = fba_pkg::FW'({dw_i, {fba_pkg::WB_LOG{1'b0}}});

  // frame 0 and frames at or above the limit count as taken
  assign clr   = ~word_i & fba_pkg::range_mask(base, (fba_pkg::FW+1)'(1), {1'b0, lim_i});
  assign tz    = fba_pkg::lsb_index(~clr);
  assign lz    = fba_pkg::lsb_index(fba_pkg::bit_rev(~clr));
  assign carry = ({1'b0, run_i} + (fba_pkg::FW+1)'(tz)) >= {1'b0, cnt_i};
  assign win   = (cnt_i < fba_pkg::FW'(fba_pkg::WORD_BITS)) ?
                 fba_pkg::window(clr, cnt_i[fba_pkg::WB_LOG-1:0]) : '0;
  assign p     = fba_pkg::lsb_index(win);

  always_comb begin
    fit_o.hit      = carry || (|win);
    fit_o.start    = carry ? start_i : base + fba_pkg::FW'(p);
    fit_o.run_nx   = (&clr) ? run_i + fba_pkg::FW'(fba_pkg::WORD_BITS) : fba_pkg::FW'(lz);
    fit_o.start_nx = (&clr) ? start_i :
                     base + fba_pkg::FW'(fba_pkg::WORD_BITS) - fba_pkg::FW'(lz);
  end

  assign mask        = fba_pkg::range_mask(base, lo_i, hi_i);
  assign rng_o.wdata = set_i ? (word_i | mask) : (word_i & ~mask);
  assign rng_o.n     = fba_pkg::popcount(set_i ? (mask & ~word_i) : (mask & word_i));

  assign zpos         = fba_pkg::lsb_index(~word_i);
  assign low_o.found  = ~&word_i;
  assign low_o.bitpos = zpos[fba_pkg::WB_LOG-1:0];

endmodule

// File: design/frame_bitmap_allocator.sv
`timescale 1ns / 1ps
// Query and free-one read the one bitmap word that holds the frame and report; init writes
// every bitmap word in turn; scans and range passes read the words they visit in order, and
// a first-fit search is followed by its marking pass. One item at a time: a new item is
// accepted only in idle. Reset clears control and counters and loads the configuration
// defaults; the bitmap RAM, with one read and one write port, is filled by init.
module frame_bitmap_allocator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,  // func[2:0], frame_index[14:3], frame_count[27:15]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,  // ok[0], frame_out[12:1], is_free[13], free_count[26:14]
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_addr_i,
  input  logic [12:0] cfg_data_i
);

  localparam int unsigned AW = fba_pkg::AW;
  localparam int unsigned FW = fba_pkg::FW;
  localparam int unsigned IW = fba_pkg::IW;
  localparam int unsigned WL = fba_pkg::WB_LOG;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_INIT  = 3'd1;
  localparam logic [2:0] ST_ALLOC = 3'd2;
  localparam logic [2:0] ST_FIT   = 3'd3;
  localparam logic [2:0] ST_RANGE = 3'd4;
  localparam logic [2:0] ST_ONE   = 3'd5;
  localparam logic [2:0] ST_FIN   = 3'd6;

  localparam logic REG_FRAME_LIMIT = 1'b0;
  localparam logic REG_RESERVED    = 1'b1;

  localparam logic [FW-1:0] MAX_CNT = FW'(fba_pkg::NUM_FRAMES);

  logic [2:0]    state_q, state_d;
  logic [2:0]    func_q, func_d;
  logic [IW-1:0] idx_q, idx_d;
  logic [FW-1:0] cnt_q, cnt_d;
  logic          set_q, set_d;
  logic [FW:0]   lo_q, lo_d, hi_q, hi_d;
  logic [AW:0]   rd_ptr_q, rd_ptr_d;
  logic [AW-1:0] last_q, last_d;
  logic          vld_q, vld_d;
  logic [AW-1:0] dw_q, dw_d;
  logic [FW-1:0] run_q, run_d, start_q, start_d;
  logic          ok_q, ok_d, isfree_q, isfree_d;
  logic [IW-1:0] frame_q, frame_d;
  logic [FW-1:0] free_q, free_d;
  logic          init_q, init_d;
  logic          m_valid_q, m_valid_d;
  logic [31:0]   m_data_q, m_data_d;
  logic [FW-1:0] lim_cfg_q, res_cfg_q;

  logic [2:0]     in_func;
  logic [IW-1:0]  in_idx;
  logic [FW-1:0]  in_cnt;
  logic [FW-1:0]  lim, res_m, rl, init_free;
  logic [FW:0]    rng_sum, rng_hi, fit_hi, free_sum;
  logic           in_acc, out_free, rd_en, rd_end, streaming;
  logic           wr_en;
  logic [AW-1:0]  wr_addr;
  fba_pkg::word_t wr_data, rd_data;
  logic [IW-1:0]  low_frame;

  fba_pkg::fit_res_t ev_fit;
  fba_pkg::rng_res_t ev_rng;
  fba_pkg::low_res_t ev_low;

  assign in_func = s_axis_tdata_i[2:0];
  assign in_idx  = s_axis_tdata_i[14:3];
  assign in_cnt  = s_axis_tdata_i[27:15];

  assign lim       = (lim_cfg_q > MAX_CNT) ? MAX_CNT : lim_cfg_q;
  assign res_m     = (res_cfg_q < lim) ? res_cfg_q : lim;
  assign rl        = (res_m == '0) ? FW'(1) : res_m;
  assign init_free = (lim == '0) ? '0 : lim - rl;
  assign rng_sum   = {2'b00, in_idx} + {1'b0, in_cnt};
  assign rng_hi    = (rng_sum > {1'b0, lim}) ? {1'b0, lim} : rng_sum;
  assign fit_hi    = {1'b0, ev_fit.start} + {1'b0, cnt_q};
  assign free_sum  = {1'b0, free_q} + (FW+1)'(ev_rng.n);
  assign low_frame = {dw_q, ev_low.bitpos};

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !m_valid_q || m_axis_tready_i;
  assign cfg_ready_o     = 1'b1;
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

  assign streaming = (state_q == ST_ALLOC) || (state_q == ST_FIT) ||
                     (state_q == ST_RANGE) || (state_q == ST_ONE);
  assign rd_end    = rd_ptr_q > {1'b0, last_q};
  assign rd_en     = streaming && !rd_end;

  fba_map u_map (
    .clk_i     (clk_i),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_ptr_q[AW-1:0]),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data)
  );

  fba_word_eval u_eval (
    .word_i  (rd_data),
    .dw_i    (dw_q),
    .lim_i   (lim),
    .cnt_i   (cnt_q),
    .lo_i    (lo_q),
    .hi_i    (hi_q),
    .set_i   (set_q),
    .run_i   (run_q),
    .start_i (start_q),
    .fit_o   (ev_fit),
    .rng_o   (ev_rng),
    .low_o   (ev_low)
  );

  always_comb begin
    state_d   = state_q;
    func_d    = func_q;
    idx_d     = idx_q;
    cnt_d     = cnt_q;
    set_d     = set_q;
    lo_d      = lo_q;
    hi_d      = hi_q;
    rd_ptr_d  = rd_ptr_q;
    last_d    = last_q;
    dw_d      = rd_ptr_q[AW-1:0];
    run_d     = run_q;
    start_d   = start_q;
    ok_d      = ok_q;
    isfree_d  = isfree_q;
    frame_d   = frame_q;
    free_d    = free_q;
    init_d    = init_q;
    m_valid_d = m_valid_q;
    m_data_d  = m_data_q;
    wr_en     = 1'b0;
    wr_addr   = dw_q;
    wr_data   = ev_rng.wdata;

    if (m_axis_tready_i) m_valid_d = 1'b0;
    if (rd_en) rd_ptr_d = rd_ptr_q + (AW+1)'(1);

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          func_d   = in_func;
          idx_d    = in_idx;
          cnt_d    = in_cnt;
          ok_d     = 1'b0;
          isfree_d = 1'b0;
          frame_d  = '0;
          run_d    = '0;
          start_d  = '0;
          rd_ptr_d = '0;
          state_d  = ST_FIN;
          if (in_func == fba_pkg::FN_INIT) begin
            if (!init_q) state_d = ST_INIT;
          end else if (init_q) begin
            unique case (in_func)
              fba_pkg::FN_ALLOC: begin
                last_d = AW'(fba_pkg::MAP_WORDS - 1);
                if (free_q != '0) state_d = ST_ALLOC;
              end
              fba_pkg::FN_FREE: begin
                rd_ptr_d = {1'b0, in_idx[IW-1:WL]};
                last_d   = in_idx[IW-1:WL];
                if (in_idx != '0 && {1'b0, in_idx} < lim) begin
                  ok_d    = 1'b1;
                  state_d = ST_ONE;
                end
              end
              fba_pkg::FN_ALLOC_R: begin
                last_d = AW'((lim - FW'(1)) >> WL);
                if (in_cnt != '0 && free_q >= in_cnt && lim >= FW'(2)) state_d = ST_FIT;
              end
              fba_pkg::FN_FREE_R, fba_pkg::FN_RESERVE: begin
                set_d    = (in_func == fba_pkg::FN_RESERVE);
                lo_d     = {2'b00, in_idx};
                hi_d     = rng_hi;
                rd_ptr_d = {1'b0, in_idx[IW-1:WL]};
                last_d   = AW'((rng_hi - (FW+1)'(1)) >> WL);
                if (in_func == fba_pkg::FN_RESERVE || in_idx != '0) begin
                  ok_d = 1'b1;
                  if ({2'b00, in_idx} < rng_hi) state_d = ST_RANGE;
                end
              end
              fba_pkg::FN_QUERY: begin
                ok_d     = 1'b1;
                rd_ptr_d = {1'b0, in_idx[IW-1:WL]};
                last_d   = in_idx[IW-1:WL];
                if ({1'b0, in_idx} < lim) state_d = ST_ONE;
              end
              default: state_d = ST_FIN;
            endcase
          end
        end
      end

      ST_INIT: begin
        wr_en    = 1'b1;
        wr_addr  = rd_ptr_q[AW-1:0];
        wr_data  = fba_pkg::range_mask(FW'({rd_ptr_q[AW-1:0], {WL{1'b0}}}), '0, {1'b0, rl});
        rd_ptr_d = rd_ptr_q + (AW+1)'(1);
        if (rd_ptr_q[AW-1:0] == AW'(fba_pkg::MAP_WORDS - 1)) begin
          init_d  = 1'b1;
          ok_d    = 1'b1;
          free_d  = init_free;
          state_d = ST_FIN;
        end
      end

      ST_ALLOC: begin
        if (vld_q) begin
          if (ev_low.found) begin
            // first clear bit decides, even when it falls beyond the limit
            if (low_frame != '0 && {1'b0, low_frame} < lim) begin
              wr_en   = 1'b1;
              wr_data = rd_data | (fba_pkg::word_t'(1) << ev_low.bitpos);
              free_d  = free_q - FW'(1);
              ok_d    = 1'b1;
              frame_d = low_frame;
            end
            state_d = ST_FIN;
          end else if (dw_q == last_q) begin
            state_d = ST_FIN;
          end
        end
      end

      ST_FIT: begin
        if (vld_q) begin
          if (ev_fit.hit) begin
            // run found: mark it with a reserve pass over its words
            ok_d     = 1'b1;
            frame_d  = ev_fit.start[IW-1:0];
            set_d    = 1'b1;
            lo_d     = {1'b0, ev_fit.start};
            hi_d     = fit_hi;
            rd_ptr_d = {1'b0, ev_fit.start[IW-1:WL]};
            last_d   = AW'((fit_hi - (FW+1)'(1)) >> WL);
            state_d  = ST_RANGE;
          end else begin
            run_d   = ev_fit.run_nx;
            start_d = ev_fit.start_nx;
            if (dw_q == last_q) state_d = ST_FIN;
          end
        end
      end

      ST_RANGE: begin
        if (vld_q) begin
          wr_en = 1'b1;
          if (set_q) free_d = ({1'b0, free_q} < (FW+1)'(ev_rng.n)) ? '0 :
                              free_q - FW'(ev_rng.n);
          else       free_d = (free_sum > {1'b0, MAX_CNT}) ? MAX_CNT : free_sum[FW-1:0];
          if (dw_q == last_q) state_d = ST_FIN;
        end
      end

      ST_ONE: begin
        if (vld_q) begin
          if (func_q == fba_pkg::FN_QUERY) begin
            isfree_d = !rd_data[idx_q[WL-1:0]];
          end else if (rd_data[idx_q[WL-1:0]]) begin
            wr_en   = 1'b1;
            wr_data = rd_data & ~(fba_pkg::word_t'(1) << idx_q[WL-1:0]);
            if (free_q < MAX_CNT) free_d = free_q + FW'(1);
          end
          state_d = ST_FIN;
        end
      end

      ST_FIN: begin
        if (out_free) begin
          m_valid_d = 1'b1;
          m_data_d  = {5'b0, free_q, isfree_q, frame_q, ok_q};
          state_d   = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase

    // drop reads that were in flight when the state changed
    vld_d = rd_en && (state_d == state_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      vld_q     <= 1'b0;
      free_q    <= '0;
      init_q    <= 1'b0;
      m_valid_q <= 1'b0;
      lim_cfg_q <= FW'(4096);
      res_cfg_q <= FW'(256);
    end else begin
      state_q   <= state_d;
      vld_q     <= vld_d;
      free_q    <= free_d;
      init_q    <= init_d;
      m_valid_q <= m_valid_d;
      if (cfg_valid_i) begin
        if (cfg_addr_i == REG_FRAME_LIMIT) lim_cfg_q <= cfg_data_i;
        if (cfg_addr_i == REG_RESERVED)    res_cfg_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    func_q   <= func_d;
    idx_q    <= idx_d;
    cnt_q    <= cnt_d;
    set_q    <= set_d;
    lo_q     <= lo_d;
    hi_q     <= hi_d;
    rd_ptr_q <= rd_ptr_d;
    last_q   <= last_d;
    dw_q     <= dw_d;
    run_q    <= run_d;
    start_q  <= start_d;
    ok_q     <= ok_d;
    isfree_q <= isfree_d;
    frame_q  <= frame_d;
    m_data_q <= m_data_d;
  end

`ifndef SYNTHESIS
  a_free_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_q <= MAX_CNT) else $error("free count above frame maximum");

  a_uninit_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !init_q |-> free_q == '0) else $error("free count nonzero before init");

  a_write_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> (state_q == ST_INIT || state_q == ST_ALLOC || state_q == ST_RANGE ||
               state_q == ST_ONE)) else $error("bitmap write outside an operation");

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q != ST_IDLE) else $error("item accepted without starting work");
`endif

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 1ps

class fba_board;
  bit          frame_map [4096];
  int unsigned free_total;
  bit          inited;
  int unsigned limit_reg;
  int unsigned resv_reg;
  logic [26:0] pending [$];
  int unsigned errors;
  int unsigned checked;
  int unsigned ok_seen;

  function new();
    limit_reg = 4096;
    resv_reg  = 256;
  endfunction

  function bit frame_busy(int unsigned f);
    if (f >= 4096) return 1'b1;
    return frame_map[f];
  endfunction

  function void take_frame(int unsigned f);
    if (f < 4096) frame_map[f] = 1'b1;
    if (free_total > 0) free_total--;
  endfunction

  function void give_frame(int unsigned f);
    if (f < 4096) frame_map[f] = 1'b0;
    if (free_total < 4096) free_total++;
  endfunction

  function int unsigned lowest_clear();
    for (int f = 0; f < 4096; f++)
      if (!frame_map[f]) return f;
    return 0;
  endfunction

  function int unsigned first_fit(int unsigned cnt, int unsigned lim);
    int unsigned start;
    int unsigned run;
    start = 1;
    run   = 0;
    for (int unsigned i = 1; i < lim; i++) begin
      if (frame_busy(i)) begin
        start = i + 1;
        run   = 0;
      end else begin
        run++;
        if (run >= cnt) return start;
      end
    end
    return 0;
  endfunction

  // Work out the result of one accepted item and queue it.
  function void note_item(logic [2:0] fn, logic [11:0] ix, logic [12:0] cnt);
    int unsigned lim;
    int unsigned f;
    bit          ok;
    bit          isfree;
    int unsigned fout;
    lim    = (limit_reg > 4096) ? 4096 : limit_reg;
    ok     = 0;
    isfree = 0;
    fout   = 0;
    if (fn == fba_pkg::FN_INIT) begin
      if (!inited) begin
        foreach (frame_map[i]) frame_map[i] = 1'b0;
        free_total   = lim;
        frame_map[0] = 1'b1;
        if (lim > 0 && free_total > 0) free_total--;
        for (int unsigned i = 0; i < resv_reg && i < lim; i++)
          if (!frame_map[i]) take_frame(i);
        inited = 1;
        ok     = 1;
      end
    end else if (inited) begin
      case (fn)
        fba_pkg::FN_ALLOC: begin
          if (free_total != 0) begin
            f = lowest_clear();
            if (f != 0 && f < lim) begin
              take_frame(f);
              ok   = 1;
              fout = f;
            end
          end
        end
        fba_pkg::FN_FREE: begin
          if (ix != 0 && ix < lim) begin
            ok = 1;
            if (frame_busy(ix)) give_frame(ix);
          end
        end
        fba_pkg::FN_ALLOC_R: begin
          if (cnt != 0 && free_total >= cnt) begin
            f = first_fit(cnt, lim);
            if (f != 0) begin
              for (int unsigned i = 0; i < cnt; i++)
                if (f + i < 4096) frame_map[f + i] = 1'b1;
              free_total -= cnt;
              ok   = 1;
              fout = f;
            end
          end
        end
        fba_pkg::FN_FREE_R: begin
          if (ix != 0) begin
            ok = 1;
            for (int unsigned i = 0; i < cnt && ix + i < lim; i++)
              if (frame_busy(ix + i)) give_frame(ix + i);
          end
        end
        fba_pkg::FN_RESERVE: begin
          ok = 1;
          for (int unsigned i = 0; i < cnt && ix + i < lim; i++)
            if (!frame_busy(ix + i)) take_frame(ix + i);
        end
        fba_pkg::FN_QUERY: begin
          ok     = 1;
          isfree = (ix < lim) && !frame_busy(ix);
        end
        default: ;
      endcase
    end
    pending.push_back({free_total[12:0], isfree, fout[11:0], ok});
  endfunction

  function void check_result(logic [31:0] d);
    logic [26:0] e;
    if (pending.size() == 0) begin
      $error("result item with nothing expected: %h", d);
      errors++;
      return;
    end
    e = pending.pop_front();
    checked++;
    if (d[0]) ok_seen++;
    if (d[0] !== e[0]) begin
      $error("ok: expected %0d, got %0d", e[0], d[0]);
      errors++;
    end
    if (d[12:1] !== e[12:1]) begin
      $error("frame_out: expected %0d, got %0d", e[12:1], d[12:1]);
      errors++;
    end
    if (d[13] !== e[13]) begin
      $error("is_free: expected %0d, got %0d", e[13], d[13]);
      errors++;
    end
    if (d[26:14] !== e[26:14]) begin
      $error("free_count: expected %0d, got %0d", e[26:14], d[26:14]);
      errors++;
    end
  endfunction
endclass

module tb_top;

  localparam logic       REG_LIMIT = 1'b0;
  localparam logic       REG_RESV  = 1'b1;
  localparam logic [2:0] FN_UNUSED = 3'd7;
  localparam int         STALL_MAX = 20000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_tvalid = 1'b0;
  logic [31:0] s_tdata = '0;
  logic        m_tready = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_addr = 1'b0;
  logic [12:0] cfg_data = '0;
  logic        s_axis_tready_o;
  logic        m_axis_tvalid_o;
  logic [31:0] m_axis_tdata_o;
  logic        cfg_ready_o;

  int unsigned src_idle;
  int unsigned snk_idle;
  int unsigned stall_cycles;
  int unsigned items_sent;
  fba_board    board;

  frame_bitmap_allocator DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_addr_i      (cfg_addr),
    .cfg_data_i      (cfg_data)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (m_axis_tvalid_o && m_tready) board.check_result(m_axis_tdata_o);
    m_tready <= ($urandom_range(99) >= snk_idle);
  end

  // Abort when no channel moves anything for too long.
  always @(posedge clk_i) begin
    if ((s_tvalid && s_axis_tready_o) || (m_axis_tvalid_o && m_tready) ||
        (cfg_valid && cfg_ready_o)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles > STALL_MAX) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  task automatic send_item(input logic [2:0] fn, input logic [11:0] ix,
                           input logic [12:0] cnt);
    if ($urandom_range(99) < src_idle) begin
      s_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < src_idle);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {4'b0, cnt, ix, fn};
    do @(posedge clk_i); while (!s_axis_tready_o);
    board.note_item(fn, ix, cnt);
    items_sent++;
  endtask

  // Drop valid and hold until every queued result has come back.
  task automatic drain();
    s_tvalid <= 1'b0;
    do @(posedge clk_i); while (board.pending.size() != 0);
  endtask

  task automatic cfg_write(input logic a, input logic [12:0] v);
    cfg_valid <= 1'b1;
    cfg_addr  <= a;
    cfg_data  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (a == REG_LIMIT) board.limit_reg = v;
    else board.resv_reg = v;
    cfg_valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic random_items(input int n, input int unsigned lim);
    logic [2:0]  fn;
    logic [11:0] ix;
    logic [12:0] cnt;
    int unsigned top;
    top = (lim == 0) ? 1 : ((lim > 4096) ? 4096 : lim);
    for (int k = 0; k < n; k++) begin
      fn  = 3'($urandom_range(1, 6));
      if ($urandom_range(49) == 0) fn = 3'($urandom_range(7));
      ix  = ($urandom_range(9) == 0) ? 12'($urandom) : 12'($urandom_range(top - 1));
      case ($urandom_range(19))
        0:       cnt = 13'($urandom);
        1, 2:    cnt = 13'($urandom_range(64, 600));
        default: cnt = 13'($urandom_range(0, 40));
      endcase
      // keep the map from filling up: turn half of the reserves into range frees
      if (fn == fba_pkg::FN_RESERVE && $urandom_range(1)) fn = fba_pkg::FN_FREE_R;
      send_item(fn, ix, cnt);
      if ($urandom_range(149) == 0) drain();
    end
  endtask

  initial begin
    board = new();
    src_idle = 7;
    snk_idle = 61;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    cfg_write(REG_RESV, 13'd4096);
    cfg_write(REG_LIMIT, 13'd8191);
    cfg_write(REG_LIMIT, 13'd1000);
    cfg_write(REG_RESV, 13'd37);

    // everything fails before init; then init twice and edge cases on indices and counts
    send_item(fba_pkg::FN_QUERY, 12'd5, 13'd0);
    send_item(fba_pkg::FN_ALLOC, 12'hFFF, 13'h1FFF);
    send_item(fba_pkg::FN_FREE, 12'd40, 13'd1);
    send_item(FN_UNUSED, 12'd0, 13'd0);
    send_item(fba_pkg::FN_INIT, 12'd0, 13'd0);
    send_item(fba_pkg::FN_INIT, 12'd0, 13'd0);
    send_item(fba_pkg::FN_ALLOC, 12'd0, 13'd0);
    send_item(fba_pkg::FN_FREE, 12'd0, 13'd0);
    send_item(fba_pkg::FN_FREE, 12'hFFF, 13'd0);
    send_item(fba_pkg::FN_FREE, 12'd900, 13'd0);
    send_item(fba_pkg::FN_ALLOC_R, 12'd0, 13'd0);
    send_item(fba_pkg::FN_ALLOC_R, 12'd0, 13'd4096);
    send_item(fba_pkg::FN_ALLOC_R, 12'd0, 13'd5);
    send_item(fba_pkg::FN_FREE_R, 12'd0, 13'd10);
    send_item(fba_pkg::FN_FREE_R, 12'd3, 13'd20);
    send_item(fba_pkg::FN_FREE_R, 12'hFFF, 13'h1FFF);
    send_item(fba_pkg::FN_RESERVE, 12'd990, 13'd30);
    send_item(fba_pkg::FN_RESERVE, 12'd0, 13'd0);
    send_item(fba_pkg::FN_QUERY, 12'hFFF, 13'd0);
    send_item(fba_pkg::FN_QUERY, 12'd0, 13'd0);
    send_item(fba_pkg::FN_QUERY, 12'd1, 13'd0);
    send_item(fba_pkg::FN_ALLOC, 12'd0, 13'd0);
    send_item(FN_UNUSED, 12'hFFF, 13'h1FFF);
    drain();

    random_items(250, 1000);
    drain();
    cfg_write(REG_LIMIT, 13'd4096);
    random_items(200, 4096);
    drain();
    src_idle = 61;
    snk_idle = 7;
    cfg_write(REG_LIMIT, 13'd0);
    random_items(60, 0);
    drain();
    cfg_write(REG_LIMIT, 13'd8191);
    random_items(200, 4096);
    drain();
    src_idle = 0;
    snk_idle = 0;
    cfg_write(REG_LIMIT, 13'd300);
    random_items(150, 300);
    drain();
    cfg_write(REG_LIMIT, 13'd2500);
    random_items(150, 2500);
    drain();

    repeat (300) @(posedge clk_i);
    $display("sent %0d items, checked %0d results (%0d successful)",
             items_sent, board.checked, board.ok_seen);
    $display("frame limits 1000, 4096, 0, 8191, 300, 2500 after init with 37 reserved");
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule

// File: files.f
design/fba_pkg.sv
design/fba_map.sv
design/fba_word_eval.sv
design/frame_bitmap_allocator.sv
bench/tb_top.sv
